>>> src/delayed_order_fill_queue_macros.svh
// Assertion macros shared by the fill queue RTL.
`ifndef DELAYED_ORDER_FILL_QUEUE_MACROS_SVH
`define DELAYED_ORDER_FILL_QUEUE_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define DOFQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an event is followed by a consequence in the next cycle.
`define DOFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dofq_pkg.sv
// Types and constants of the delayed order fill queue.
package dofq_pkg;

  localparam int unsigned MaxFires = 16;
  localparam int unsigned FireW    = 5;

  typedef enum logic {
    CMD_SUBMIT = 1'b0,
    CMD_TICK   = 1'b1
  } dofq_cmd_e;

  typedef enum logic [2:0] {
    KIND_QUEUED    = 3'd0,
    KIND_REJ_PRICE = 3'd1,
    KIND_REJ_FULL  = 3'd2,
    KIND_FILLED    = 3'd3,
    KIND_NONE_DUE  = 3'd4
  } dofq_kind_e;

  typedef enum logic [1:0] {
    CFG_SLIPPAGE = 2'd0,
    CFG_LATENCY  = 2'd1
  } dofq_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_EMIT
  } dofq_state_e;

  typedef struct packed {
    logic        command;
    logic [31:0] ord_id;
    logic        is_buy;
    logic        is_market;
    logic [31:0] limit_price;
    logic [31:0] quantity;
    logic [63:0] now_time;
    logic        bid_present;
    logic [31:0] bid_px;
    logic        ask_present;
    logic [31:0] ask_px;
  } dofq_cmd_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] out_order_id;
    logic        out_is_buy;
    logic [31:0] exec_price;
    logic [31:0] exec_qty;
    logic [63:0] event_time;
    logic [4:0]  fired_count;
    logic [31:0] total_fills;
    logic [31:0] total_rejects;
    logic [63:0] total_filled_qty;
    logic        last;
  } dofq_res_t;

  typedef struct packed {
    logic [31:0] ord_id;
    logic        is_buy;
    logic [31:0] quantity;
    logic [63:0] due_time;
    logic [31:0] price;
  } dofq_slot_t;

endpackage

>>> src/dofq_price.sv
// Fill price of a submitted order from the quote, limit and slippage.
module dofq_price import dofq_pkg::*; (
  input  dofq_cmd_t   cmd_i,
  input  logic [31:0] slippage_i,
  output logic [31:0] price_o
);

  logic [32:0] buy_sum;

  assign buy_sum = {1'b0, cmd_i.ask_px} + {1'b0, slippage_i};

  always_comb begin
    price_o = '0;
    if (cmd_i.is_buy) begin
      if (cmd_i.ask_present &&
          (cmd_i.is_market || cmd_i.ask_px <= cmd_i.limit_price)) begin
        price_o = buy_sum[32] ? '1 : buy_sum[31:0];
      end
    end else begin
      if (cmd_i.bid_present &&
          (cmd_i.is_market || cmd_i.bid_px >= cmd_i.limit_price)) begin
        price_o = (cmd_i.bid_px > slippage_i) ? cmd_i.bid_px - slippage_i : 32'd1;
      end
    end
  end

endmodule

>>> src/delayed_order_fill_queue.sv
// Top level of the delayed order fill queue.
// Commands enter on cmd_i, taken when start_i is high and busy_o is low.
// A submit prices the order at once and answers in the next cycle with one
// result (queued or rejected); a queued order is written to the slot memory.
// busy_o stays low for a submit, so submits may follow every cycle.
// A tick walks the slot memory at one entry a cycle through its single
// read port: a counting pass for the number of due fills, then, if any is
// due, an emitting pass that puts out each due fill (up to 16) and compacts
// the rest in place; with nothing due it instead answers with a single
// "nothing due" result.
// Each result sits on res_o for one cycle with res_valid_o high; res_o.last
// marks the final result of a command. The receiver cannot stall.
// Configuration writes on cfg_valid_i/cfg_ready_o are taken at any time but
// are meant for idle periods; index 0 is slippage, index 1 fill latency.
// Reset empties the queue and clears the totals and registers; no sweep
// of the memory is needed since a slot count tracks the valid slots.
module delayed_order_fill_queue import dofq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  dofq_cmd_t   cmd_i,
  output logic        res_valid_o,
  output dofq_res_t   res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

`include "delayed_order_fill_queue_macros.svh"

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(QUEUE_DEPTH);
  localparam logic [FireW-1:0] FireCap = FireW'(MaxFires);

  dofq_state_e state_q, state_d;
  logic [31:0] slip_q, lat_q;
  logic [CntW-1:0] cnt_q, cnt_d, rd_ptr_q, rd_ptr_d, keep_q, keep_d, pidx_q;
  logic pv_q, pv_d;
  logic [FireW-1:0] fired_q, fired_d, nemit_q, nemit_d;
  logic [63:0] now_q, now_d;
  logic [31:0] fills_q, fills_d, rejs_q, rejs_d;
  logic [63:0] qsum_q, qsum_d;
  dofq_res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  dofq_slot_t mem [QUEUE_DEPTH];
  dofq_slot_t rd_data_q, wr_data;
  logic wr_en;
  logic [IdxW-1:0] wr_addr;

  logic [31:0] price;
  logic [64:0] due_sum;
  logic [64:0] qsum_add;
  logic accept, issue, pass_done, is_due;

  dofq_price u_price (
    .cmd_i      (cmd_i),
    .slippage_i (slip_q),
    .price_o    (price)
  );

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign issue     = (rd_ptr_q < cnt_q);
  assign pass_done = !issue && !pv_q;
  assign is_due    = (rd_data_q.due_time <= now_q);
  assign due_sum   = {1'b0, cmd_i.now_time} + {33'd0, lat_q};
  assign qsum_add  = {1'b0, qsum_q} + {33'd0, rd_data_q.quantity};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && cmd_i.command == CMD_TICK) state_d = ST_COUNT;
      ST_COUNT: if (pass_done) state_d = (fired_q == '0) ? ST_IDLE : ST_EMIT;
      ST_EMIT:  if (pass_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    keep_d      = keep_q;
    pv_d        = 1'b0;
    fired_d     = fired_q;
    nemit_d     = nemit_q;
    now_d       = now_q;
    fills_d     = fills_q;
    rejs_d      = rejs_q;
    qsum_d      = qsum_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cnt_q[IdxW-1:0];
    wr_data     = rd_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i.command == CMD_SUBMIT) begin
            res_valid_d            = 1'b1;
            res_d.out_order_id     = cmd_i.ord_id;
            res_d.out_is_buy       = cmd_i.is_buy;
            res_d.exec_price       = '0;
            res_d.exec_qty         = '0;
            res_d.event_time       = cmd_i.now_time;
            res_d.fired_count      = '0;
            res_d.last             = 1'b1;
            if (price == '0 || cnt_q == Depth) begin
              res_d.result_kind = (price == '0) ? KIND_REJ_PRICE : KIND_REJ_FULL;
              if (rejs_q != '1) rejs_d = rejs_q + 32'd1;
            end else begin
              res_d.result_kind = KIND_QUEUED;
              res_d.exec_price  = price;
              wr_en             = 1'b1;
              wr_data.ord_id    = cmd_i.ord_id;
              wr_data.is_buy    = cmd_i.is_buy;
              wr_data.quantity  = cmd_i.quantity;
              wr_data.due_time  = due_sum[64] ? '1 : due_sum[63:0];
              wr_data.price     = price;
              cnt_d             = cnt_q + CntW'(1);
            end
            res_d.total_fills      = fills_q;
            res_d.total_rejects    = rejs_d;
            res_d.total_filled_qty = qsum_q;
          end else begin
            now_d    = cmd_i.now_time;
            rd_ptr_d = '0;
            fired_d  = '0;
          end
        end
      end
      ST_COUNT: begin
        if (issue) begin
          rd_ptr_d = rd_ptr_q + CntW'(1);
          pv_d     = 1'b1;
        end
        if (pv_q && is_due && fired_q < FireCap) fired_d = fired_q + FireW'(1);
        if (pass_done) begin
          rd_ptr_d = '0;
          keep_d   = '0;
          nemit_d  = '0;
          if (fired_q == '0) begin
            res_valid_d            = 1'b1;
            res_d.result_kind      = KIND_NONE_DUE;
            res_d.out_order_id     = '0;
            res_d.out_is_buy       = 1'b0;
            res_d.exec_price       = '0;
            res_d.exec_qty         = '0;
            res_d.event_time       = now_q;
            res_d.fired_count      = '0;
            res_d.total_fills      = fills_q;
            res_d.total_rejects    = rejs_q;
            res_d.total_filled_qty = qsum_q;
            res_d.last             = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          rd_ptr_d = rd_ptr_q + CntW'(1);
          pv_d     = 1'b1;
        end
        if (pv_q) begin
          if (is_due && nemit_q < fired_q) begin
            nemit_d = nemit_q + FireW'(1);
            if (fills_q != '1) fills_d = fills_q + 32'd1;
            qsum_d                 = qsum_add[64] ? '1 : qsum_add[63:0];
            res_valid_d            = 1'b1;
            res_d.result_kind      = KIND_FILLED;
            res_d.out_order_id     = rd_data_q.ord_id;
            res_d.out_is_buy       = rd_data_q.is_buy;
            res_d.exec_price       = rd_data_q.price;
            res_d.exec_qty         = rd_data_q.quantity;
            res_d.event_time       = now_q;
            res_d.fired_count      = fired_q;
            res_d.total_fills      = fills_d;
            res_d.total_rejects    = rejs_q;
            res_d.total_filled_qty = qsum_d;
            res_d.last             = (nemit_d == fired_q);
          end else begin
            // keep slot lags the read pointer, so no clash with the read
            wr_en   = 1'b1;
            wr_addr = keep_q[IdxW-1:0];
            keep_d  = keep_q + CntW'(1);
          end
        end
        if (pass_done) cnt_d = keep_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[rd_ptr_q[IdxW-1:0]];
    res_q     <= res_d;
    pidx_q    <= rd_ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slip_q      <= '0;
      lat_q       <= '0;
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      keep_q      <= '0;
      pv_q        <= 1'b0;
      fired_q     <= '0;
      nemit_q     <= '0;
      now_q       <= '0;
      fills_q     <= '0;
      rejs_q      <= '0;
      qsum_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      keep_q      <= keep_d;
      pv_q        <= pv_d;
      fired_q     <= fired_d;
      nemit_q     <= nemit_d;
      now_q       <= now_d;
      fills_q     <= fills_d;
      rejs_q      <= rejs_d;
      qsum_q      <= qsum_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_index_i == CFG_SLIPPAGE) slip_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CFG_LATENCY)  lat_q  <= cfg_data_i;
    end
  end

  `DOFQ_ASSERT(a_cnt_bound, cnt_q <= Depth, "slot count beyond queue depth")
  `DOFQ_ASSERT(a_emit_bound, state_q != ST_EMIT || nemit_q <= fired_q,
               "more fills emitted than counted")
  `DOFQ_ASSERT(a_keep_lags, !(state_q == ST_EMIT && pv_q) || keep_q <= pidx_q,
               "compaction slot ahead of scan")
  `DOFQ_ASSERT_NEXT(a_submit_answer, accept && cmd_i.command == CMD_SUBMIT,
                    res_valid_q && res_q.last, "submit gave no single result")

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the delayed order fill queue.
`timescale 1ns / 100ps

module testbench;
  import dofq_pkg::*;

  localparam int unsigned Depth = 16;
  localparam logic [31:0] U32Max = 32'hFFFF_FFFF;
  localparam logic [63:0] U64Max = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  dofq_cmd_t   cmd;
  logic        res_valid;
  dofq_res_t   res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  delayed_order_fill_queue u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .cmd_i      (cmd),
    .res_valid_o(res_valid),
    .res_o      (res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // predictor state
  logic [31:0] slip_q, lat_q;
  dofq_slot_t  book_q[$];
  logic [31:0] fills_q, rejects_q;
  logic [63:0] qty_sum_q;

  dofq_cmd_t   pending_cmds[$];
  dofq_res_t   expected_res[$];
  int unsigned n_errors, n_items, n_results, n_fills;
  bit          idle_gaps;
  bit          taken;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [31:0] order_price(dofq_cmd_t c);
    logic [32:0] sum;
    if (c.is_buy) begin
      if (!c.ask_present || (!c.is_market && c.ask_px > c.limit_price)) return '0;
      sum = {1'b0, c.ask_px} + {1'b0, slip_q};
      return sum[32] ? U32Max : sum[31:0];
    end
    if (!c.bid_present || (!c.is_market && c.bid_px < c.limit_price)) return '0;
    return (c.bid_px > slip_q) ? c.bid_px - slip_q : 32'd1;
  endfunction

  function automatic dofq_res_t make_res(dofq_kind_e k, dofq_slot_t s, logic [31:0] qty,
                                         logic [63:0] t, logic [4:0] fired);
    dofq_res_t r;
    r.result_kind      = k;
    r.out_order_id     = s.ord_id;
    r.out_is_buy       = s.is_buy;
    r.exec_price       = s.price;
    r.exec_qty         = qty;
    r.event_time       = t;
    r.fired_count      = fired;
    r.total_fills      = fills_q;
    r.total_rejects    = rejects_q;
    r.total_filled_qty = qty_sum_q;
    r.last             = 1'b0;
    return r;
  endfunction

  task automatic predict_fills(dofq_cmd_t c);
    dofq_slot_t s, kept[$];
    dofq_res_t  outs[$];
    logic [64:0] sum;
    int unsigned fired;
    fired = 0;
    foreach (book_q[i]) if (book_q[i].due_time <= c.now_time && fired < 16) fired++;
    foreach (book_q[i]) begin
      s = book_q[i];
      if (s.due_time <= c.now_time && outs.size() < 16) begin
        if (fills_q != U32Max) fills_q++;
        sum = {1'b0, qty_sum_q} + {33'd0, s.quantity};
        qty_sum_q = sum[64] ? U64Max : sum[63:0];
        outs = {outs, make_res(KIND_FILLED, s, s.quantity, c.now_time, fired[4:0])};
      end else begin
        kept = {kept, s};
      end
    end
    book_q = kept;
    if (outs.size() == 0) begin
      s = '0;
      outs = {outs, make_res(KIND_NONE_DUE, s, '0, c.now_time, '0)};
    end
    outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) expected_res = {expected_res, outs[i]};
  endtask

  task automatic predict_submit(dofq_cmd_t c);
    dofq_slot_t s;
    dofq_res_t  r;
    logic [64:0] due;
    s.ord_id   = c.ord_id;
    s.is_buy   = c.is_buy;
    s.quantity = c.quantity;
    s.price    = order_price(c);
    due        = {1'b0, c.now_time} + {33'd0, lat_q};
    s.due_time = due[64] ? U64Max : due[63:0];
    if (s.price == '0 || book_q.size() >= Depth) begin
      if (rejects_q != U32Max) rejects_q++;
      if (s.price == '0) r = make_res(KIND_REJ_PRICE, s, '0, c.now_time, '0);
      else r = make_res(KIND_REJ_FULL, s, '0, c.now_time, '0);
      r.exec_price = '0;
    end else begin
      book_q = {book_q, s};
      r = make_res(KIND_QUEUED, s, '0, c.now_time, '0);
    end
    r.last = 1'b1;
    expected_res = {expected_res, r};
  endtask

  // driver: a new item once the previous one was taken at the last rising edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || taken) begin
        if (pending_cmds.size() != 0 && !(idle_gaps && $urandom_range(99) < 28)) begin
          cmd   <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // prediction on acceptance and result checking
  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch @%0t %s: got %0h want %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin
    dofq_res_t w;
    if (rst_n) begin
      if (res_valid) begin
        n_results++;
        if (expected_res.size() == 0) begin
          report("unexpected result", 64'(res.result_kind), 64'd0);
        end else begin
          w = expected_res.pop_front();
          if (res.result_kind == KIND_FILLED) n_fills++;
          if (res.result_kind != w.result_kind)
            report("kind", 64'(res.result_kind), 64'(w.result_kind));
          if (res.out_order_id != w.out_order_id)
            report("order id", 64'(res.out_order_id), 64'(w.out_order_id));
          if (res.out_is_buy != w.out_is_buy)
            report("side", 64'(res.out_is_buy), 64'(w.out_is_buy));
          if (res.exec_price != w.exec_price)
            report("price", 64'(res.exec_price), 64'(w.exec_price));
          if (res.exec_qty != w.exec_qty)
            report("qty", 64'(res.exec_qty), 64'(w.exec_qty));
          if (res.event_time != w.event_time) report("time", res.event_time, w.event_time);
          if (res.fired_count != w.fired_count)
            report("fired", 64'(res.fired_count), 64'(w.fired_count));
          if (res.total_fills != w.total_fills)
            report("fills", 64'(res.total_fills), 64'(w.total_fills));
          if (res.total_rejects != w.total_rejects)
            report("rejects", 64'(res.total_rejects), 64'(w.total_rejects));
          if (res.total_filled_qty != w.total_filled_qty)
            report("qty sum", res.total_filled_qty, w.total_filled_qty);
          if (res.last != w.last) report("last", 64'(res.last), 64'(w.last));
        end
      end
      taken = start && !busy;
      if (taken) begin
        n_items++;
        if (cmd.command == CMD_TICK) predict_fills(cmd);
        else predict_submit(cmd);
      end
    end
  end

  function automatic logic [31:0] rand32();
    case ($urandom_range(5))
      0: return '0;
      1: return U32Max;
      2: return $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  // submit with a random quote near a running price level
  function automatic dofq_cmd_t rand_submit(logic [63:0] t);
    dofq_cmd_t c;
    logic [31:0] mid;
    c = '0;
    c.command     = CMD_SUBMIT;
    c.ord_id      = $urandom;
    c.is_buy      = 1'($urandom_range(1));
    c.is_market   = 1'($urandom_range(1));
    c.quantity    = rand32();
    c.now_time    = t;
    mid           = ($urandom_range(9) == 0) ? rand32() : 32'd1000 + $urandom_range(40);
    c.bid_present = $urandom_range(9) != 0;
    c.ask_present = $urandom_range(9) != 0;
    c.bid_px      = mid - $urandom_range(5);
    c.ask_px      = mid + $urandom_range(5);
    c.limit_price = ($urandom_range(7) == 0) ? rand32() : mid + $urandom_range(20) - 32'd10;
    return c;
  endfunction

  function automatic dofq_cmd_t tick_at(logic [63:0] t);
    dofq_cmd_t c;
    c = '0;
    c.command  = CMD_TICK;
    c.now_time = t;
    return c;
  endfunction

  task automatic wait_drain();
    while (pending_cmds.size() != 0 || start || busy || expected_res.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(dofq_cfg_e idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SLIPPAGE) slip_q = val;
    else lat_q = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    dofq_cmd_t c;
    logic [63:0] t;
    logic [31:0] slips[4], lats[4];
    rst_n = 1'b0; start = 1'b0; cmd = '0; taken = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    slip_q = '0; lat_q = '0; fills_q = '0; rejects_q = '0; qty_sum_q = '0;
    n_errors = 0; n_items = 0; n_results = 0; n_fills = 0; idle_gaps = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: extremes, each reject path, saturation, full queue
    write_reg(CFG_SLIPPAGE, 32'd5);
    write_reg(CFG_LATENCY, 32'd100);
    c = '0; c.is_buy = 1'b1; c.is_market = 1'b1; c.ask_present = 1'b1; c.ask_px = U32Max;
    c.ord_id = U32Max; c.quantity = U32Max; c.now_time = 64'd10;
    pending_cmds = {pending_cmds, c};          // buy price saturates
    c.ask_px = '0; c.ord_id = 32'd1;
    pending_cmds = {pending_cmds, c};          // market buy at 5
    c.ask_present = 1'b0; pending_cmds = {pending_cmds, c}; // no ask
    c = '0; c.is_market = 1'b1; c.bid_present = 1'b1; c.bid_px = 32'd3; c.ord_id = 32'd2;
    c.quantity = 32'd7; pending_cmds = {pending_cmds, c}; // sell clamps to 1
    c.is_market = 1'b0; c.limit_price = 32'd4;
    pending_cmds = {pending_cmds, c};          // sell limit fails
    c.limit_price = 32'd3; c.bid_px = U32Max; c.bid_present = 1'b0;
    pending_cmds = {pending_cmds, c};          // no bid
    c = '0; c.is_buy = 1'b1; c.ask_present = 1'b1; c.ask_px = 32'd50;
    c.limit_price = 32'd49;
    pending_cmds = {pending_cmds, c};          // buy limit fails
    c.limit_price = 32'd50; c.now_time = U64Max;
    pending_cmds = {pending_cmds, c};          // due saturates
    pending_cmds = {pending_cmds, tick_at(64'd50)};   // nothing due
    pending_cmds = {pending_cmds, tick_at(64'd110)};  // early ones due
    for (int i = 0; i < 15; i++) pending_cmds = {pending_cmds, rand_submit(64'd200)};
    pending_cmds = {pending_cmds, tick_at(U64Max)};   // drains everything
    wait_drain();
    write_reg(CFG_SLIPPAGE, '0);
    write_reg(CFG_LATENCY, '0);
    c = '0; c.is_buy = 1'b1; c.is_market = 1'b1; c.ask_present = 1'b1; c.ask_px = '0;
    pending_cmds = {pending_cmds, c};          // zero buy price
    for (int i = 0; i < 18; i++) pending_cmds = {pending_cmds, rand_submit(64'd5)}; // overfill
    pending_cmds = {pending_cmds, tick_at(64'd5)};
    wait_drain();

    // random phases over several register settings
    slips = '{32'd0, 32'd3, U32Max, 32'd1000};
    lats  = '{32'd0, 32'd50, U32Max, 32'd7};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_SLIPPAGE, slips[ph]);
      write_reg(CFG_LATENCY, lats[ph]);
      idle_gaps = (ph != 1);
      t = (ph == 2) ? U64Max - 64'd3000 : 64'd1000 * 64'(ph);
      for (int i = 0; i < 70; i++) begin
        t = t + 64'($urandom_range(20));
        if ($urandom_range(3) == 0) pending_cmds = {pending_cmds, tick_at(t)};
        else pending_cmds = {pending_cmds, rand_submit(t)};
        if (i == 35) wait_drain(); // hold off until all answered
      end
      pending_cmds = {pending_cmds, tick_at(U64Max)};
      wait_drain();
    end

    $display("ran %0d items, %0d results checked, %0d fills", n_items, n_results, n_fills);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
